/* src/normalize_vector_fixed_point_assert.svh */
// Assertion macros shared by the vector normaliser RTL.
// Each macro expects clk and rst_n to be in scope in the module that uses it.
`ifndef NORMALIZE_VECTOR_FIXED_POINT_ASSERT_SVH
`define NORMALIZE_VECTOR_FIXED_POINT_ASSERT_SVH

// Same-cycle implication, suspended during reset
`define NVF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nvf assertion failed");

// Next-cycle implication, suspended during reset
`define NVF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nvf assertion failed");

`endif

/* src/nvf_pkg.sv */
// Shared constants for the vector normaliser.
// No dependencies; used by nvf_front, nvf_cell and the top level.
package nvf_pkg;

  // Default component width of the input vector
  localparam int COMPONENT_WIDTH_DEF = 24;
  // Default number of fraction bits of the unit vector
  localparam int FRACTION_BITS_DEF   = 12;
  // Number of vector components, one lane each
  localparam int LANES               = 3;

endpackage

/* src/nvf_front.sv */
// Front end of the normaliser: component magnitudes, squares, sum of squares.
// Depends on nvf_pkg only.
module nvf_front #(
  parameter int CW = nvf_pkg::COMPONENT_WIDTH_DEF,
  parameter int F  = nvf_pkg::FRACTION_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [nvf_pkg::LANES-1:0][CW-1:0]           comp,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [2*CW-1:0]                             s,
  output logic [nvf_pkg::LANES-1:0][2*CW+2*F-2:0]     r,
  output logic [nvf_pkg::LANES-1:0]                   neg,
  output logic [nvf_pkg::LANES-1:0]                   nz
);

  localparam int SQW = 2*CW - 1;
  localparam int SW  = 2*CW;
  localparam int RW  = 2*CW + 2*F - 1;

  logic                                   a_v_r;
  logic [nvf_pkg::LANES-1:0][SQW-1:0]     a_sq_r, a_sq_nxt;
  logic [nvf_pkg::LANES-1:0]              a_neg_r, a_nz_r;
  logic                                   a_ready;

  logic                                   b_v_r;
  logic [SW-1:0]                          b_s_r, b_s_nxt;
  logic [nvf_pkg::LANES-1:0][RW-1:0]      b_r_r, b_r_nxt;
  logic [nvf_pkg::LANES-1:0]              b_neg_r, b_nz_r;
  logic                                   b_ready;

  logic [nvf_pkg::LANES-1:0][CW-1:0]      mag;
  logic [nvf_pkg::LANES-1:0][2*CW-1:0]    prod;

  // Magnitude and square of each component
  always_comb begin
    for (int i = 0; i < nvf_pkg::LANES; i++) begin
      mag[i]      = comp[i][CW-1] ? (~comp[i] + 1'b1) : comp[i];
      prod[i]     = {{CW{1'b0}}, mag[i]} * {{CW{1'b0}}, mag[i]};
      a_sq_nxt[i] = prod[i][SQW-1:0];
    end
  end

  assign b_ready  = !b_v_r || out_ready;
  assign a_ready  = !a_v_r || b_ready;
  assign in_ready = a_ready;

  // Stage A: squares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_ready) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      a_sq_r <= a_sq_nxt;
      for (int i = 0; i < nvf_pkg::LANES; i++) begin
        a_neg_r[i] <= comp[i][CW-1];
        a_nz_r[i]  <= |comp[i];
      end
    end
  end

  // Sum of squares and scaled squares as starting remainders
  always_comb begin
    b_s_nxt = '0;
    for (int i = 0; i < nvf_pkg::LANES; i++) begin
      b_s_nxt    = b_s_nxt + SW'(a_sq_r[i]);
      b_r_nxt[i] = {a_sq_r[i], {(2*F){1'b0}}};
    end
  end

  // Stage B
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_ready) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_v_r && b_ready) begin
      b_s_r   <= b_s_nxt;
      b_r_r   <= b_r_nxt;
      b_neg_r <= a_neg_r;
      b_nz_r  <= a_nz_r;
    end
  end

  assign out_valid = b_v_r;
  assign s         = b_s_r;
  assign r         = b_r_r;
  assign neg       = b_neg_r;
  assign nz        = b_nz_r;

endmodule

/* src/nvf_cell.sv */
// One cell of the normaliser chain: decides one quotient bit for all lanes.
// Depends on nvf_pkg and normalize_vector_fixed_point_assert.svh.
`include "normalize_vector_fixed_point_assert.svh"

module nvf_cell #(
  parameter int CW  = nvf_pkg::COMPONENT_WIDTH_DEF,
  parameter int F   = nvf_pkg::FRACTION_BITS_DEF,
  parameter int BIT = 0
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [2*CW-1:0]                             s_in,
  input  logic [nvf_pkg::LANES-1:0][2*CW+2*F-2:0]     r_in,
  input  logic [nvf_pkg::LANES-1:0][2*CW+F:0]         p_in,
  input  logic [nvf_pkg::LANES-1:0][F:0]              q_in,
  input  logic [nvf_pkg::LANES-1:0]                   neg_in,
  input  logic [nvf_pkg::LANES-1:0]                   nz_in,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [2*CW-1:0]                             s_out,
  output logic [nvf_pkg::LANES-1:0][2*CW+2*F-2:0]     r_out,
  output logic [nvf_pkg::LANES-1:0][2*CW+F:0]         p_out,
  output logic [nvf_pkg::LANES-1:0][F:0]              q_out,
  output logic [nvf_pkg::LANES-1:0]                   neg_out,
  output logic [nvf_pkg::LANES-1:0]                   nz_out
);

  localparam int SW   = 2*CW;
  localparam int RW   = 2*CW + 2*F - 1;
  localparam int PW   = 2*CW + F + 1;
  localparam int QW   = F + 1;
  localparam int CMPW = 2*CW + 2*F + 2;
  localparam logic [QW-1:0] QBIT = QW'(1) << BIT;
  localparam logic [QW-1:0] LOWM = QBIT - QW'(1);

  logic                                   v_r;
  logic [SW-1:0]                          s_r;
  logic [nvf_pkg::LANES-1:0][RW-1:0]      r_r, r_nxt;
  logic [nvf_pkg::LANES-1:0][PW-1:0]      p_r, p_nxt;
  logic [nvf_pkg::LANES-1:0][QW-1:0]      q_r, q_nxt;
  logic [nvf_pkg::LANES-1:0]              neg_r, nz_r;
  logic [nvf_pkg::LANES-1:0][CMPW-1:0]    d;
  logic [nvf_pkg::LANES-1:0]              take;

  // Trial: (q + 2^b)^2*S - q^2*S = 2^(b+1)*q*S + 2^(2b)*S, with P = q*S
  always_comb begin
    for (int i = 0; i < nvf_pkg::LANES; i++) begin
      d[i]     = (CMPW'(p_in[i]) << (BIT + 1)) + (CMPW'(s_in) << (2*BIT));
      take[i]  = CMPW'(r_in[i]) >= d[i];
      r_nxt[i] = take[i] ? (r_in[i] - d[i][RW-1:0]) : r_in[i];
      p_nxt[i] = take[i] ? (p_in[i] + (PW'(s_in) << BIT)) : p_in[i];
      q_nxt[i] = take[i] ? (q_in[i] | QBIT) : q_in[i];
    end
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_r   <= s_in;
      r_r   <= r_nxt;
      p_r   <= p_nxt;
      q_r   <= q_nxt;
      neg_r <= neg_in;
      nz_r  <= nz_in;
    end
  end

  assign out_valid = v_r;
  assign s_out     = s_r;
  assign r_out     = r_r;
  assign p_out     = p_r;
  assign q_out     = q_r;
  assign neg_out   = neg_r;
  assign nz_out    = nz_r;

  // A stalled cell keeps its item
  `NVF_ASSERT_NEXT(a_cell_hold, v_r && !out_ready, v_r && $stable(q_r))
  // Bits below this cell's position are still undecided in lanes 0 and 1
  `NVF_ASSERT_IMPL(a_cell_low, v_r, ((q_r[0] & LOWM) == '0) && ((q_r[1] & LOWM) == '0))

endmodule

/* src/normalize_vector_fixed_point.sv */
// Top level of the three-component vector normaliser (1.F fixed point output).
// Depends on nvf_pkg, nvf_front, nvf_cell and normalize_vector_fixed_point_assert.svh.
//
// Usage:
//   Input stream in_*: one vector per transfer, components x, y, z in in_tdata.
//   Output stream out_*: one unit vector per input vector, in the same order.
//   Each result component is c * 2^F / |v| truncated toward zero, sign of c;
//   a zero vector or a zero component gives zero.
// Pipeline: FRACTION_BITS + 4 register stages (two front stages, one chain cell
//   per quotient bit, one output register).
// Throughput: one vector per cycle unless stalled. Every stage is a register with
//   its own valid bit; the chain of FRACTION_BITS+1 cells each settles one quotient
//   bit by shift, add and compare, so a new vector enters while older ones advance.
// Reset: rst_n (synchronous, active low) empties the pipeline; no state beyond.
// Stall: while out_tready is low the output register holds its result;
//   bubbles in the chain still close up, and in_tready drops only once the
//   stages ahead of the input are all occupied.
`include "normalize_vector_fixed_point_assert.svh"

module normalize_vector_fixed_point #(
  parameter int COMPONENT_WIDTH = nvf_pkg::COMPONENT_WIDTH_DEF,
  parameter int FRACTION_BITS   = nvf_pkg::FRACTION_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // x_in, y_in, z_in from bit 0 up, zero padded to whole bytes
  input  logic [((nvf_pkg::LANES*COMPONENT_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // x_unit, y_unit, z_unit from bit 0 up, zero padded to whole bytes
  output logic [((nvf_pkg::LANES*(FRACTION_BITS+2)+7)/8)*8-1:0] out_tdata
);

  localparam int CW   = COMPONENT_WIDTH;
  localparam int F    = FRACTION_BITS;
  localparam int NL   = nvf_pkg::LANES;
  localparam int SW   = 2*CW;
  localparam int RW   = 2*CW + 2*F - 1;
  localparam int PW   = 2*CW + F + 1;
  localparam int QW   = F + 1;
  localparam int OW   = F + 2;
  localparam int OTW  = ((NL*OW+7)/8)*8;
  localparam int NC   = F + 1;
  localparam logic [QW-1:0] QMAX = QW'(1) << F;

  // Chain links: index 0 is the front end, index k+1 the output of cell k
  logic [NC:0]                        ch_v, ch_rdy;
  logic [NC:0][SW-1:0]                ch_s;
  logic [NC:0][NL-1:0][RW-1:0]        ch_r;
  logic [NC:0][NL-1:0][PW-1:0]        ch_p;
  logic [NC:0][NL-1:0][QW-1:0]        ch_q;
  logic [NC:0][NL-1:0]                ch_neg, ch_nz;

  logic [NL-1:0][CW-1:0]              comp;

  // Unpack the input components
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      comp[i] = in_tdata[i*CW +: CW];
    end
  end

  nvf_front #(
    .CW (CW),
    .F  (F)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .comp      (comp),
    .out_valid (ch_v[0]),
    .out_ready (ch_rdy[0]),
    .s         (ch_s[0]),
    .r         (ch_r[0]),
    .neg       (ch_neg[0]),
    .nz        (ch_nz[0])
  );

  assign ch_p[0] = '0;
  assign ch_q[0] = '0;

  // One cell per quotient bit, most significant first
  for (genvar k = 0; k < NC; k++) begin : g_cell
    nvf_cell #(
      .CW  (CW),
      .F   (F),
      .BIT (F - k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (ch_v[k]),
      .in_ready  (ch_rdy[k]),
      .s_in      (ch_s[k]),
      .r_in      (ch_r[k]),
      .p_in      (ch_p[k]),
      .q_in      (ch_q[k]),
      .neg_in    (ch_neg[k]),
      .nz_in     (ch_nz[k]),
      .out_valid (ch_v[k+1]),
      .out_ready (ch_rdy[k+1]),
      .s_out     (ch_s[k+1]),
      .r_out     (ch_r[k+1]),
      .p_out     (ch_p[k+1]),
      .q_out     (ch_q[k+1]),
      .neg_out   (ch_neg[k+1]),
      .nz_out    (ch_nz[k+1])
    );
  end

  // Output register
  logic             out_valid_r;
  logic [OTW-1:0]   out_data_r, out_data_nxt;
  logic [OW-1:0]    mag_w;
  logic             q_in_range;

  assign ch_rdy[NC] = !out_valid_r || out_tready;

  // Apply sign, force zero components, pack
  always_comb begin
    out_data_nxt = '0;
    mag_w        = '0;
    for (int i = 0; i < NL; i++) begin
      mag_w = ch_nz[NC][i] ? OW'(ch_q[NC][i]) : '0;
      out_data_nxt[i*OW +: OW] = ch_neg[NC][i] ? (~mag_w + 1'b1) : mag_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ch_rdy[NC]) begin
      out_valid_r <= ch_v[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (ch_v[NC] && ch_rdy[NC]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // All three quotients at the end of the chain are at most one in 1.F
  assign q_in_range = (ch_q[NC][0] <= QMAX) && (ch_q[NC][1] <= QMAX)
                      && (ch_q[NC][2] <= QMAX);

  // A finished item entering the output register shows up as valid
  `NVF_ASSERT_NEXT(a_out_load, ch_v[NC] && ch_rdy[NC], out_valid_r)
  // Quotient never exceeds one in 1.F format when all components are nonzero
  `NVF_ASSERT_IMPL(a_q_range, ch_v[NC] && (ch_nz[NC] == '1), q_in_range)

endmodule
